// ===== hdl/keyed_replay_filter_table_top_assert.svh =====
// ----------------------------------------------------------------------------
// Keyed replay filter table assertion macros
// Concurrent checks on the table's control logic, empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef KEYED_REPLAY_FILTER_TABLE_TOP_ASSERT_SVH
`define KEYED_REPLAY_FILTER_TABLE_TOP_ASSERT_SVH
`ifndef SYNTH
`define KRFT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyed replay filter table check failed");
`define KRFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyed replay filter table check failed");
`else
`define KRFT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define KRFT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/krft_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyed replay filter table package
// Sizes, operation and status codes, and item and entry types.
// ----------------------------------------------------------------------------
`default_nettype none

package krft_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic [2:0] MODE_ADD    = 3'd0;
    localparam logic [2:0] MODE_DELETE = 3'd1;
    localparam logic [2:0] MODE_SET_EN = 3'd2;
    localparam logic [2:0] MODE_QRY_EN = 3'd3;
    localparam logic [2:0] MODE_CHECK  = 3'd4;
    localparam logic [2:0] MODE_CLEAR  = 3'd5;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_DISABLED  = 2'd3;

    typedef struct packed {
        logic [2:0]  mode;
        logic [47:0] peer_address;
        logic [15:0] peer_product;
        logic [31:0] counter_value;
        logic        enable_value;
        logic        replay_strict;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic       accepted;
        logic [4:0] entry_count;
    } t_result;

    typedef struct packed {
        logic [47:0] address;
        logic [15:0] product;
        logic [31:0] counter;
        logic        enabled;
    } t_entry;

endpackage

`default_nettype wire

// ===== hdl/keyed_replay_filter_table_top.sv =====
// ----------------------------------------------------------------------------
// Keyed replay filter table
// Peer table keyed by address and product id with frame counter replay check.
// ----------------------------------------------------------------------------
// Channel   Ports                               Transfer
// request   start, busy, i_req                  start high while busy low
// result    o_result_valid, o_result            one cycle strobe, no stall
//
// A lookup walks the entry memory one entry per cycle, then the apply state
// applies the operation and registers the result; the scan stops early on a
// key match. Clear all and unused codes answer in the next cycle.
// Synchronous reset empties the table at once. The result strobe cannot be
// stalled; busy holds off the next item.
// ----------------------------------------------------------------------------
`default_nettype none

`include "keyed_replay_filter_table_top_assert.svh"

module keyed_replay_filter_table_top
    import krft_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire t_req    i_req,
    output logic         o_result_valid,
    output t_result      o_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY
    } t_state;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

    t_state                   r_state;
    t_req                     r_req;
    logic [IDX_W-1:0]         r_ptr;
    logic                     r_hit;
    logic [IDX_W-1:0]         r_hit_idx;
    t_entry                   r_hit_entry;
    logic                     r_free;
    logic [IDX_W-1:0]         r_free_idx;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [CNT_W-1:0]         r_count;
    logic                     r_out_vld;
    t_result                  r_out;

    t_entry                   r_mem [TABLE_ENTRIES];
    t_entry                   r_rd_entry;

    logic [IDX_W-1:0]         rd_addr;
    logic                     key_hit;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    t_entry                   wr_data;
    logic                     set_valid;
    logic                     clr_valid;
    logic [1:0]               n_status;
    logic                     n_accepted;
    logic [CNT_W-1:0]         n_count;
    logic [31:0]              cnt_diff;
    logic                     cnt_pass;
    logic [CNT_W+4:0]         cnt_ext;
    logic [CNT_W+4:0]         cnt_cur_ext;

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_out_vld;
    assign o_result       = r_out;

    assign rd_addr = (r_state == S_SCAN) ? r_ptr + IDX_W'(1) : '0;
    assign key_hit = r_valid[r_ptr]
                   && (r_rd_entry.address == r_req.peer_address)
                   && (r_rd_entry.product == r_req.peer_product);

    assign cnt_diff = r_req.counter_value - r_hit_entry.counter;
    assign cnt_pass = (r_req.counter_value != r_hit_entry.counter)
                   && (!r_req.replay_strict || (r_hit_entry.counter == 32'd0)
                       || ((cnt_diff != 32'd0) && !cnt_diff[31]));

    always_comb begin
        wr_en      = 1'b0;
        wr_addr    = r_hit_idx;
        wr_data    = r_hit_entry;
        set_valid  = 1'b0;
        clr_valid  = 1'b0;
        n_status   = STAT_OK;
        n_accepted = 1'b0;
        n_count    = r_count;
        unique case (r_req.mode)
            MODE_ADD: begin
                if (r_count >= FULL_CNT) begin
                    n_status = STAT_FULL;
                end else if (r_hit) begin
                    wr_en           = 1'b1;
                    wr_data.counter = 32'd0;
                end else if (r_free) begin
                    wr_en           = 1'b1;
                    wr_addr         = r_free_idx;
                    wr_data.address = r_req.peer_address;
                    wr_data.product = r_req.peer_product;
                    wr_data.counter = r_req.counter_value;
                    wr_data.enabled = r_req.enable_value;
                    set_valid       = 1'b1;
                    n_count         = r_count + CNT_W'(1);
                end else begin
                    n_status = STAT_FULL;
                end
            end
            MODE_DELETE: begin
                if (!r_hit) begin
                    n_status = STAT_NOT_FOUND;
                end else begin
                    clr_valid = 1'b1;
                    n_count   = r_count - CNT_W'(1);
                end
            end
            MODE_SET_EN: begin
                if (!r_hit) begin
                    n_status = STAT_NOT_FOUND;
                end else begin
                    wr_en           = 1'b1;
                    wr_data.enabled = r_req.enable_value;
                end
            end
            MODE_QRY_EN: begin
                if (!r_hit) begin
                    n_status = STAT_NOT_FOUND;
                end else if (!r_hit_entry.enabled) begin
                    n_status = STAT_DISABLED;
                end
            end
            MODE_CHECK: begin
                if (!r_hit) begin
                    n_status = STAT_NOT_FOUND;
                end else if (cnt_pass) begin
                    wr_en           = 1'b1;
                    wr_data.counter = r_req.counter_value;
                    n_accepted      = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (r_state != S_APPLY) begin
            wr_en     = 1'b0;
            set_valid = 1'b0;
            clr_valid = 1'b0;
        end
    end

    assign cnt_ext     = {5'd0, n_count};
    assign cnt_cur_ext = {5'd0, r_count};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_entry <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
        end else begin
            r_out_vld <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_req  <= i_req;
                        r_ptr  <= '0;
                        r_hit  <= 1'b0;
                        r_free <= 1'b0;
                        if (i_req.mode == MODE_CLEAR) begin
                            r_valid              <= '0;
                            r_count              <= '0;
                            r_out_vld            <= 1'b1;
                            r_out.status         <= STAT_OK;
                            r_out.accepted       <= 1'b0;
                            r_out.entry_count    <= 5'd0;
                        end else if (i_req.mode == MODE_ADD || i_req.mode == MODE_DELETE
                                     || i_req.mode == MODE_SET_EN
                                     || i_req.mode == MODE_QRY_EN
                                     || i_req.mode == MODE_CHECK) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_out_vld            <= 1'b1;
                            r_out.status         <= STAT_OK;
                            r_out.accepted       <= 1'b0;
                            r_out.entry_count    <= cnt_cur_ext[4:0];
                        end
                    end
                end
                S_SCAN: begin
                    if (key_hit) begin
                        r_hit       <= 1'b1;
                        r_hit_idx   <= r_ptr;
                        r_hit_entry <= r_rd_entry;
                        r_state     <= S_APPLY;
                    end else begin
                        if (!r_valid[r_ptr] && !r_free) begin
                            r_free     <= 1'b1;
                            r_free_idx <= r_ptr;
                        end
                        if (r_ptr == LAST_IDX) begin
                            r_state <= S_APPLY;
                        end else begin
                            r_ptr <= r_ptr + IDX_W'(1);
                        end
                    end
                end
                S_APPLY: begin
                    if (set_valid) begin
                        r_valid[r_free_idx] <= 1'b1;
                    end
                    if (clr_valid) begin
                        r_valid[r_hit_idx] <= 1'b0;
                    end
                    r_count           <= n_count;
                    r_out_vld         <= 1'b1;
                    r_out.status      <= n_status;
                    r_out.accepted    <= n_accepted;
                    r_out.entry_count <= cnt_ext[4:0];
                    r_state           <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `KRFT_ASSERT_NOW(a_count_matches_valid, i_clk, i_rst_n, 1'b1, r_count == CNT_W'($countones(r_valid)))
    `KRFT_ASSERT_NEXT(a_apply_gives_result, i_clk, i_rst_n, r_state == S_APPLY, o_result_valid && !busy)
    `KRFT_ASSERT_NOW(a_no_result_while_busy, i_clk, i_rst_n, busy, !o_result_valid)
    `KRFT_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, start && !busy && i_req.mode == MODE_CLEAR, o_result_valid && r_valid == '0)

endmodule

`default_nettype wire
